@@ rtl/ote_pkg.sv @@
`default_nettype none

package ote_pkg;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic [2:0] CMD_USE       = 3'd0;
  localparam logic [2:0] CMD_RELEASE   = 3'd1;
  localparam logic [2:0] CMD_TICK      = 3'd2;
  localparam logic [2:0] CMD_EVICT_OLD = 3'd3;
  localparam logic [2:0] CMD_EVICT_ANY = 3'd4;

  // The frame counter starts here after reset.
  localparam logic [31:0] FRAME_RESET = 32'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] entry;
    logic       evictable;
  } ote_in_t;

  typedef struct packed {
    logic       evicted;
    logic [7:0] victim;
  } ote_out_t;

  // One table word: flags and the frame stamp of the last use.
  typedef struct packed {
    logic        resident;
    logic        reloadable;
    logic [31:0] last_use;
  } ote_ent_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REL,
    S_SCAN,
    S_EVW,
    S_DONE
  } ote_state_t;

endpackage

`default_nettype wire

@@ rtl/ote_scan.sv @@
`default_nettype none

module ote_scan import ote_pkg::*; #(
  parameter int IW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   limit,
  input  wire logic          any_en,
  input  wire logic          chk_vld,
  input  wire logic [IW-1:0] chk_idx,
  input  wire ote_ent_t      chk_ent,
  output logic               pick_found,
  output logic [IW-1:0]      pick_idx,
  output logic [31:0]        pick_stamp
);

  logic          old_found_r, old_found_nxt;
  logic [IW-1:0] old_idx_r, old_idx_nxt;
  logic [31:0]   old_best_r, old_best_nxt;
  logic          any_found_r, any_found_nxt;
  logic [IW-1:0] any_idx_r, any_idx_nxt;
  logic [31:0]   any_best_r, any_best_nxt;
  logic          cand;

  // Both searches run in the same pass. The age search keeps the first entry
  // with a strictly smaller stamp; the fallback keeps the last one that ties.
  always_comb begin
    cand          = chk_vld && chk_ent.resident && chk_ent.reloadable;
    old_found_nxt = old_found_r;
    old_idx_nxt   = old_idx_r;
    old_best_nxt  = old_best_r;
    any_found_nxt = any_found_r;
    any_idx_nxt   = any_idx_r;
    any_best_nxt  = any_best_r;
    if (start) begin
      old_found_nxt = 1'b0;
      old_best_nxt  = limit;
      any_found_nxt = 1'b0;
      any_best_nxt  = '1;
    end else begin
      if (cand && (chk_ent.last_use < old_best_r)) begin
        old_found_nxt = 1'b1;
        old_idx_nxt   = chk_idx;
        old_best_nxt  = chk_ent.last_use;
      end
      if (cand && (chk_ent.last_use <= any_best_r)) begin
        any_found_nxt = 1'b1;
        any_idx_nxt   = chk_idx;
        any_best_nxt  = chk_ent.last_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_found_r <= 1'b0;
      any_found_r <= 1'b0;
    end else begin
      old_found_r <= old_found_nxt;
      any_found_r <= any_found_nxt;
    end
    old_idx_r  <= old_idx_nxt;
    old_best_r <= old_best_nxt;
    any_idx_r  <= any_idx_nxt;
    any_best_r <= any_best_nxt;
  end

  assign pick_found = old_found_r || (any_en && any_found_r);
  assign pick_idx   = old_found_r ? old_idx_r : any_idx_r;
  assign pick_stamp = old_found_r ? old_best_r : any_best_r;

endmodule

`default_nettype wire

@@ rtl/oldest_texture_eviction_top.sv @@
`default_nettype none

// Channel  Direction  Signals                         Payload
// in       input      in_valid / in_ready / in_data   ote_in_t  {cmd, entry, evictable}
// out      output     out_valid / out_ready / out_data ote_out_t {evicted, victim}
//
// Every input transaction returns exactly one output transaction. Use, frame tick and
// unknown commands go straight to the hand-off; release first reads the table word,
// then writes it back. An eviction steps through the accept, one table read per entry,
// the judging of the last word, the victim write and the hand-off to the output register.
// After reset a clearing pass zeroes the table with in_ready held low.
// A finished result waits in the output register while the next transaction is worked on;
// only the hand-off of a second result stalls.

module oldest_texture_eviction_top import ote_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ote_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ote_out_t      out_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // The whole table: flags and stamps side by side in one memory word.
  ote_ent_t mem [ENTRIES];

  ote_state_t    state_r, state_nxt;
  ote_in_t       cmd_r, cmd_nxt;
  logic [31:0]   frame_r, frame_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic          chk_last_r, chk_last_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  ote_ent_t      rd_data_r;
  ote_out_t      res_r, res_nxt;
  ote_out_t      out_r, out_nxt;
  logic          out_vld_r, out_vld_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ote_ent_t      wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          scan_start;
  logic          in_range_new;
  logic          in_range_cur;
  logic          pick_found;
  logic [IW-1:0] pick_idx;
  logic [31:0]   pick_stamp;

  assign in_range_new = (32'(in_data.entry) < 32'(ENTRIES));
  assign in_range_cur = (32'(cmd_r.entry) < 32'(ENTRIES));

  ote_scan #(
    .IW(IW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .limit     (frame_r - 32'd1),
    .any_en    (cmd_r.cmd == CMD_EVICT_ANY),
    .chk_vld   (chk_vld_r),
    .chk_idx   (chk_idx_r),
    .chk_ent   (rd_data_r),
    .pick_found(pick_found),
    .pick_idx  (pick_idx),
    .pick_stamp(pick_stamp)
  );

  // Control. Only one transaction is in the table pipeline at a time, and each
  // one finishes its write before the next is accepted, so a read never sees
  // a stale word and no forwarding path is needed.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    frame_nxt    = frame_r;
    clr_cnt_nxt  = clr_cnt_r;
    iss_cnt_nxt  = iss_cnt_r;
    chk_vld_nxt  = 1'b0;
    chk_last_nxt = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    scan_start   = 1'b0;
    in_ready     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r[IW-1:0];
        clr_cnt_nxt = clr_cnt_r + CW'(1);
        if (clr_cnt_r == CW'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_data;
          res_nxt = '0;
          unique case (in_data.cmd) inside
            CMD_USE: begin
              // A use writes the whole word at once; there is nothing to read.
              wr_en              = in_range_new;
              wr_addr            = IW'(in_data.entry);
              wr_data.resident   = 1'b1;
              wr_data.reloadable = in_data.evictable;
              wr_data.last_use   = frame_r;
              state_nxt          = S_DONE;
            end
            CMD_RELEASE: begin
              rd_en     = 1'b1;
              rd_addr   = IW'(in_data.entry);
              state_nxt = S_REL;
            end
            CMD_TICK: begin
              frame_nxt = frame_r + 32'd1;
              state_nxt = S_DONE;
            end
            CMD_EVICT_OLD, CMD_EVICT_ANY: begin
              scan_start  = 1'b1;
              iss_cnt_nxt = '0;
              state_nxt   = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_REL: begin
        // Only a reloadable entry may drop out of the table.
        if (in_range_cur && rd_data_r.reloadable) begin
          wr_en              = 1'b1;
          wr_addr            = IW'(cmd_r.entry);
          wr_data.resident   = 1'b0;
          wr_data.reloadable = 1'b1;
          wr_data.last_use   = rd_data_r.last_use;
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        // Reads are issued in index order; each word is judged in the cycle after its read.
        if (iss_cnt_r < CW'(ENTRIES)) begin
          rd_en        = 1'b1;
          rd_addr      = iss_cnt_r[IW-1:0];
          iss_cnt_nxt  = iss_cnt_r + CW'(1);
          chk_vld_nxt  = 1'b1;
          chk_last_nxt = (iss_cnt_r == CW'(ENTRIES - 1));
          chk_idx_nxt  = iss_cnt_r[IW-1:0];
        end
        if (chk_vld_r && chk_last_r) begin
          state_nxt = S_EVW;
        end
      end

      S_EVW: begin
        // The victim was a reloadable resident entry with the kept stamp, so
        // its word is rebuilt here without another read.
        if (pick_found) begin
          wr_en              = 1'b1;
          wr_addr            = pick_idx;
          wr_data.resident   = 1'b0;
          wr_data.reloadable = 1'b1;
          wr_data.last_use   = pick_stamp;
        end
        res_nxt.evicted = pick_found;
        res_nxt.victim  = pick_found ? 8'(pick_idx) : 8'd0;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      frame_r    <= FRAME_RESET;
      clr_cnt_r  <= '0;
      iss_cnt_r  <= '0;
      chk_vld_r  <= 1'b0;
      chk_last_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      frame_r    <= frame_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      iss_cnt_r  <= iss_cnt_nxt;
      chk_vld_r  <= chk_vld_nxt;
      chk_last_r <= chk_last_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    cmd_r     <= cmd_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Table memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // The scan is read-only; a write during it would change words still ahead.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !wr_en)
    else $error("table written during a scan");

  // Words are judged only while a scan is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == S_SCAN))
    else $error("scan check outside a scan");

  // No transaction may enter before the clearing pass has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  // A result without an eviction always reports entry zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.evicted) |-> (out_r.victim == 8'd0))
    else $error("victim index without eviction");

endmodule

`default_nettype wire

@@ bench/oldest_texture_eviction_top_test.sv @@
`timescale 1ns / 100ps

module oldest_texture_eviction_top_test;
  import ote_pkg::*;

  // The block is built with its default table size. The entry field is 8 bits
  // wide, so every index that the stimulus can produce lands inside the table.
  localparam int NUM_ENTRIES = 256;

  // Command codes 5 to 7 have no meaning. The block must answer them with an
  // empty result and leave its state alone.
  localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;

  // The slowest correct run is roughly 1700 transactions, the evictions among them
  // scanning the whole table, each stretched by random stalls on both sides. The limit
  // allows several times that much, plus the clearing pass after reset.
  localparam int CYCLE_LIMIT = 3_000_000;

  // The length of a random phase, counted in input transactions.
  localparam int PHASE_ITEMS = 425;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ote_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ote_out_t out_data;

  oldest_texture_eviction_top #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // The test bench keeps its own copy of the texture table and the frame
  // counter. This copy is updated once for each accepted input transaction.
  logic        shadow_resident   [NUM_ENTRIES];
  logic        shadow_reloadable [NUM_ENTRIES];
  logic [31:0] shadow_stamp      [NUM_ENTRIES];
  logic [31:0] shadow_frame;

  // Each accepted command adds one expected eviction result here. The results
  // leave the block in order, so the monitor always compares with the oldest.
  ote_out_t expected_evictions[$];

  int error_count    = 0;
  int issued         = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The clock has a period of 12 ns.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A cycle counter catches a hung handshake. When the limit is reached, the
  // run ends with a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls at random. The rate is set by the phase that is
  // running. Like every other input, out_ready changes at the falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // The result checker. Every transaction on the output channel must match
  // the oldest expectation, field by field.
  always @(posedge clk) begin
    ote_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_evictions.size() == 0) begin
        report_mismatch($sformatf("result evicted=%0d victim=%0d with nothing expected",
                                  out_data.evicted, out_data.victim));
      end else begin
        want = expected_evictions.pop_front();
        if (out_data.evicted !== want.evicted)
          report_mismatch($sformatf("evicted is %0d, expected %0d",
                                    out_data.evicted, want.evicted));
        if (out_data.victim !== want.victim)
          report_mismatch($sformatf("victim is %0d, expected %0d",
                                    out_data.victim, want.victim));
      end
    end
  end

  task automatic clear_shadow_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_resident[i]   = 1'b0;
      shadow_reloadable[i] = 1'b0;
      shadow_stamp[i]      = '0;
    end
    shadow_frame = FRAME_RESET;
  endtask

  // This function applies one command to the shadow table and returns the
  // eviction result that the block must produce for it.
  //
  // An old-only eviction looks for stamps that are strictly below the current
  // frame minus one. On a tie, the lowest index wins. An any-eviction falls
  // back to all reloadable resident entries when that search finds nothing.
  // In the fallback, the highest index among the oldest stamps wins.
  function automatic ote_out_t apply_command(input ote_in_t txn);
    ote_out_t    result;
    logic        found;
    int          pick;
    logic [31:0] oldest;
    result = '0;
    found  = 1'b0;
    pick   = 0;
    case (txn.cmd)
      CMD_USE: begin
        shadow_resident[txn.entry]   = 1'b1;
        shadow_reloadable[txn.entry] = txn.evictable;
        shadow_stamp[txn.entry]      = shadow_frame;
      end
      CMD_RELEASE: begin
        // A pinned entry, one that cannot be reloaded, stays resident.
        if (shadow_reloadable[txn.entry])
          shadow_resident[txn.entry] = 1'b0;
      end
      CMD_TICK: begin
        shadow_frame = shadow_frame + 32'd1;
      end
      CMD_EVICT_OLD, CMD_EVICT_ANY: begin
        oldest = shadow_frame - 32'd1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (shadow_resident[i] && shadow_reloadable[i] && shadow_stamp[i] < oldest) begin
            oldest = shadow_stamp[i];
            pick   = i;
            found  = 1'b1;
          end
        end
        if (!found && txn.cmd == CMD_EVICT_ANY) begin
          oldest = '1;
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (shadow_resident[i] && shadow_reloadable[i] && shadow_stamp[i] <= oldest) begin
              oldest = shadow_stamp[i];
              pick   = i;
              found  = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (found) begin
      shadow_resident[pick] = 1'b0;
      result.evicted        = 1'b1;
      result.victim         = pick[7:0];
    end
    return result;
  endfunction

  // This task offers one input transaction and returns at the rising edge
  // where it is accepted. Valid is left high on purpose. The next call either
  // drives the next transaction at the following falling edge or lowers valid
  // for an idle cycle, so valid is never lowered and raised in one time step.
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] entry,
                              input logic evictable);
    ote_in_t txn;
    txn.cmd       = cmd;
    txn.entry     = entry;
    txn.evictable = evictable;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= txn;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_evictions.push_back(apply_command(txn));
    issued++;
  endtask

  // This task lowers valid and waits until every expected result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_evictions.size() != 0) @(posedge clk);
  endtask

  // Most entries come from two small pools, one at each end of the index
  // range. This lets uses, releases and evictions meet on the same entries and
  // makes stamp ties common. The rest of the entries spread over the whole
  // index range.
  function automatic logic [7:0] pick_entry();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'(255 - $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 11));
    endcase
  endfunction

  // An empty table must give no victim for either kind of eviction.
  task automatic test_empty_table();
    send_command(CMD_EVICT_OLD, 8'd0, 1'b0);
    send_command(CMD_EVICT_ANY, 8'd255, 1'b1);
  endtask

  // Unknown command codes must produce an empty result and change nothing.
  task automatic test_unknown_commands();
    for (int c = CMD_FIRST_UNKNOWN; c <= CMD_LAST_UNKNOWN; c++)
      send_command(3'(c), 8'd255, 1'b1);
  endtask

  // A pinned entry ignores a release. A reloadable entry drops out of the
  // table on release, and the eviction that follows must find no victim.
  task automatic test_use_and_release();
    send_command(CMD_USE, 8'd0, 1'b0);
    send_command(CMD_USE, 8'd255, 1'b1);
    send_command(CMD_RELEASE, 8'd0, 1'b0);
    send_command(CMD_RELEASE, 8'd255, 1'b0);
    send_command(CMD_EVICT_ANY, 8'd0, 1'b0);
  endtask

  // Old-only evictions take the lowest index among the oldest stamps, and
  // only stamps below the frame minus one count. When no old stamp is left,
  // an any-eviction takes the highest index among the oldest stamps.
  task automatic test_eviction_order();
    send_command(CMD_USE, 8'd10, 1'b1);
    send_command(CMD_USE, 8'd20, 1'b1);
    send_command(CMD_TICK, 8'd0, 1'b0);
    send_command(CMD_USE, 8'd30, 1'b1);
    send_command(CMD_TICK, 8'd0, 1'b0);
    send_command(CMD_TICK, 8'd0, 1'b0);
    repeat (4) send_command(CMD_EVICT_OLD, 8'd0, 1'b0);
    send_command(CMD_USE, 8'd40, 1'b1);
    send_command(CMD_USE, 8'd50, 1'b1);
    send_command(CMD_EVICT_OLD, 8'd0, 1'b0);
    send_command(CMD_EVICT_ANY, 8'd0, 1'b0);
    send_command(CMD_EVICT_ANY, 8'd0, 1'b0);
  endtask

  // One frame of typical use: a burst of uses, a few releases, frame ticks,
  // and then evictions. All contents are random. A small share of noise
  // transactions, either unknown codes or fully random fields, mixes in.
  task automatic play_frame();
    int n_uses;
    int n_ticks;
    n_uses  = $urandom_range(1, 6);
    n_ticks = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2);
    repeat (n_uses)
      send_command(CMD_USE, pick_entry(), $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 99) < 30)
      repeat ($urandom_range(1, 2))
        send_command(CMD_RELEASE, pick_entry(), 1'($urandom_range(0, 1)));
    repeat (n_ticks)
      send_command(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 2))
      send_command($urandom_range(0, 1) ? CMD_EVICT_ANY : CMD_EVICT_OLD,
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 8)
      send_command(3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 8)
      send_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
  endtask

  // This task runs random frames at the given idle and stall rates until the
  // phase has issued its share of transactions. Then it lets the pipeline
  // drain.
  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    int target;
    target         = issued + PHASE_ITEMS;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (issued < target) play_frame();
    drain_results();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_shadow_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The directed tests run with no idling on either side. The block starts
    // with its clearing pass, and send_command simply waits for in_ready.
    test_empty_table();
    test_unknown_commands();
    test_use_and_release();
    test_eviction_order();
    drain_results();

    // The random phases give back-to-back traffic, a sender that idles about
    // half the time, a receiver that stalls about half the time, and both
    // sides at a lighter rate.
    test_random_phase(0, 0);
    test_random_phase(49, 0);
    test_random_phase(0, 49);
    test_random_phase(20, 20);

    // After the last result, the run waits one more eviction time so that a
    // stray extra result is still caught.
    repeat (NUM_ENTRIES + 8) @(posedge clk);
    if (error_count == 0 && expected_evictions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
